// File: src/esc_pkg.sv
package esc_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_TEMP_TRIM    = 3'd0;
    localparam logic [2:0] REG_PRESS_TRIM_A = 3'd1;
    localparam logic [2:0] REG_PRESS_TRIM_B = 3'd2;
    localparam logic [2:0] REG_PRESS_TRIM_C = 3'd3;
    localparam logic [2:0] REG_HUM_TRIM_A   = 3'd4;
    localparam logic [2:0] REG_HUM_TRIM_B   = 3'd5;

    // One quotient bit is resolved per divider step.
    localparam int DIV_STEPS = 64;

    // Results that ride alongside the pressure division.
    typedef struct packed {
        logic [15:0] temp;
        logic [13:0] hum;
    } t_side;

    // Partial products of a 64 x 64 multiply, low 64 bits kept.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_mpart;

    function automatic t_mpart mul_p(input logic [63:0] a, input logic [63:0] b);
        t_mpart r;
        r.ll = 64'(a[31:0]) * 64'(b[31:0]);
        r.lh = a[31:0] * b[63:32];
        r.hl = a[63:32] * b[31:0];
        return r;
    endfunction

    function automatic logic [63:0] mul_s(input t_mpart p);
        logic [31:0] hi;
        hi = p.lh + p.hl;
        return p.ll + {hi, 32'b0};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
        return 64'($signed(x) >>> sh);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
        return 32'($signed(x) >>> sh);
    endfunction

endpackage

// File: src/esc_div64.sv
module esc_div64 import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [63:0] o_quot,
    output logic        o_zero,
    output t_side       o_side
);

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [63:0] rem;
        logic [63:0] nq;
        logic [63:0] mb;
        t_side       side;
    } t_dstg;

    t_dstg r_st [0:DIV_STEPS];
    t_dstg n_st [0:DIV_STEPS];
    logic  r_vld [0:DIV_STEPS+1];
    logic [63:0] r_quot;
    logic        r_zero;
    t_side       r_side;

    // Each step shifts one dividend bit into the remainder and resolves one
    // quotient bit with a restoring subtract on the magnitudes.
    always_comb begin
        logic [63:0] trial;
        logic        ge;
        n_st[0].neg  = i_num[63] ^ i_den[63];
        n_st[0].zero = (i_den == 64'd0);
        n_st[0].rem  = 64'd0;
        n_st[0].nq   = i_num[63] ? (64'd0 - i_num) : i_num;
        n_st[0].mb   = i_den[63] ? (64'd0 - i_den) : i_den;
        n_st[0].side = i_side;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_st[k] = r_st[k-1];
            trial = {r_st[k-1].rem[62:0], r_st[k-1].nq[63]};
            ge = (trial >= r_st[k-1].mb);
            n_st[k].rem = ge ? (trial - r_st[k-1].mb) : trial;
            n_st[k].nq  = {r_st[k-1].nq[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS + 1; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= DIV_STEPS + 1; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st   <= n_st;
            r_quot <= r_st[DIV_STEPS].neg ? (64'd0 - r_st[DIV_STEPS].nq)
                                          : r_st[DIV_STEPS].nq;
            r_zero <= r_st[DIV_STEPS].zero;
            r_side <= r_st[DIV_STEPS].side;
        end
    end

    assign o_vld  = r_vld[DIV_STEPS+1];
    assign o_quot = r_quot;
    assign o_zero = r_zero;
    assign o_side = r_side;

endmodule

// File: src/env_sensor_compensation.sv
// Accepts one word per cycle while the output side is not stalled. It has 23 front
// stages, a 66-stage pressure divider resolving one quotient bit per divider step,
// and 8 back stages, all sharing one enable. Reset is synchronous and active low;
// it clears all valid bits and all coefficient registers to zero.
module env_sensor_compensation import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temperature_centi [15:0], pressure_deci_pa [47:16],
    // humidity_centi_pct [61:48], zero pad [63:62]
    output logic [63:0] m_axis_tdata
);

    localparam int NPRE  = 23;
    localparam int NPOST = 8;

    // Coefficient registers.
    logic [47:0] r_temp_trim;
    logic [63:0] r_press_trim_a;
    logic [63:0] r_press_trim_b;
    logic [15:0] r_press_trim_c;
    logic [31:0] r_hum_trim_a;
    logic [39:0] r_hum_trim_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim    <= '0;
            r_press_trim_a <= '0;
            r_press_trim_b <= '0;
            r_press_trim_c <= '0;
            r_hum_trim_a   <= '0;
            r_hum_trim_b   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_TRIM:    r_temp_trim    <= i_cfg_data[47:0];
                REG_PRESS_TRIM_A: r_press_trim_a <= i_cfg_data;
                REG_PRESS_TRIM_B: r_press_trim_b <= i_cfg_data;
                REG_PRESS_TRIM_C: r_press_trim_c <= i_cfg_data[15:0];
                REG_HUM_TRIM_A:   r_hum_trim_a   <= i_cfg_data[31:0];
                REG_HUM_TRIM_B:   r_hum_trim_b   <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Unpacked coefficients. The temperature ones are 32 bits wide, the
    // others 64, sign-extended except for the unsigned ones.
    logic [31:0] c_t1, c_t2, c_t3;
    logic [63:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    logic [63:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

    assign c_t1 = {16'd0, r_temp_trim[15:0]};
    assign c_t2 = {{16{r_temp_trim[31]}}, r_temp_trim[31:16]};
    assign c_t3 = {{16{r_temp_trim[47]}}, r_temp_trim[47:32]};
    assign c_p1 = {48'd0, r_press_trim_a[15:0]};
    assign c_p2 = {{48{r_press_trim_a[31]}}, r_press_trim_a[31:16]};
    assign c_p3 = {{48{r_press_trim_a[47]}}, r_press_trim_a[47:32]};
    assign c_p4 = {{48{r_press_trim_a[63]}}, r_press_trim_a[63:48]};
    assign c_p5 = {{48{r_press_trim_b[15]}}, r_press_trim_b[15:0]};
    assign c_p6 = {{48{r_press_trim_b[31]}}, r_press_trim_b[31:16]};
    assign c_p7 = {{48{r_press_trim_b[47]}}, r_press_trim_b[47:32]};
    assign c_p8 = {{48{r_press_trim_b[63]}}, r_press_trim_b[63:48]};
    assign c_p9 = {{48{r_press_trim_c[15]}}, r_press_trim_c};
    assign c_h1 = {56'd0, r_hum_trim_a[7:0]};
    assign c_h2 = {{48{r_hum_trim_a[23]}}, r_hum_trim_a[23:8]};
    assign c_h3 = {56'd0, r_hum_trim_a[31:24]};
    assign c_h4 = {{48{r_hum_trim_b[15]}}, r_hum_trim_b[15:0]};
    assign c_h5 = {{48{r_hum_trim_b[31]}}, r_hum_trim_b[31:16]};
    assign c_h6 = {{56{r_hum_trim_b[39]}}, r_hum_trim_b[39:32]};

    // The whole pipeline moves on one enable. The last back stage is the
    // output register, so the input side keeps accepting while a result
    // waits only if that register is free or being drained.
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Front section: temperature, then pressure operands up to the
    // division and the complete humidity result. Every 64 x 64 multiply
    // takes two stages: partial products, then their sum.
    typedef struct packed {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
        logic [31:0] tx, td, tpa, tdd, ta, tq, fine;
        logic [15:0] temp;
        logic [63:0] v1, h;
        t_mpart      mp_a, mp_b, mp_c, mp_d, mp_e, mp_f;
        logic [63:0] v1sq, v1p5, v1p2, hh5, hh6, hh3;
        logic [63:0] v1sq6, v1sq3, ha, hx, hy, hb0, v2, n1, hb1, pnum0;
        logic [63:0] vdx, pnum, hb2x, vd, hb2, hv, ss, hm, hv2;
        logic [28:0] hc;
        logic [13:0] hum;
    } t_pre;

    localparam logic [63:0] HUM_MAX = 64'd419430400;

    t_pre r_pre [1:NPRE];
    t_pre n_pre [1:NPRE];
    logic r_vpre [1:NPRE];

    always_comb begin
        logic [31:0] tr;
        logic [35:0] hs;
        n_pre[1] = '0;
        for (int k = 2; k <= NPRE; k++) n_pre[k] = r_pre[k-1];

        n_pre[1].adc_t = s_axis_tdata[19:0];
        n_pre[1].adc_p = s_axis_tdata[39:20];
        n_pre[1].adc_h = s_axis_tdata[55:40];
        n_pre[1].tx = (32'(s_axis_tdata[19:0]) >> 3) - (c_t1 << 1);
        n_pre[1].td = (32'(s_axis_tdata[19:0]) >> 4) - c_t1;

        n_pre[2].tpa = r_pre[1].tx * c_t2;
        n_pre[2].tdd = r_pre[1].td * r_pre[1].td;

        n_pre[3].ta = asr32(r_pre[2].tpa, 11);
        n_pre[3].tq = asr32(r_pre[2].tdd, 12) * c_t3;

        n_pre[4].fine = r_pre[3].ta + asr32(r_pre[3].tq, 14);

        tr = r_pre[4].fine * 32'd5 + 32'd128;
        n_pre[5].temp = 16'(asr32(tr, 8));
        n_pre[5].v1 = {{32{r_pre[4].fine[31]}}, r_pre[4].fine} - 64'd128000;
        n_pre[5].h  = {{32{r_pre[4].fine[31]}}, r_pre[4].fine} - 64'd76800;

        n_pre[6].mp_a = mul_p(r_pre[5].v1, r_pre[5].v1);
        n_pre[6].mp_b = mul_p(r_pre[5].v1, c_p5);
        n_pre[6].mp_c = mul_p(r_pre[5].v1, c_p2);
        n_pre[6].mp_d = mul_p(r_pre[5].h, c_h5);
        n_pre[6].mp_e = mul_p(r_pre[5].h, c_h6);
        n_pre[6].mp_f = mul_p(r_pre[5].h, c_h3);

        n_pre[7].v1sq = mul_s(r_pre[6].mp_a);
        n_pre[7].v1p5 = mul_s(r_pre[6].mp_b);
        n_pre[7].v1p2 = mul_s(r_pre[6].mp_c);
        n_pre[7].hh5  = mul_s(r_pre[6].mp_d);
        n_pre[7].hh6  = mul_s(r_pre[6].mp_e);
        n_pre[7].hh3  = mul_s(r_pre[6].mp_f);

        n_pre[8].mp_a = mul_p(r_pre[7].v1sq, c_p6);
        n_pre[8].mp_b = mul_p(r_pre[7].v1sq, c_p3);
        n_pre[8].ha = asr64((64'(r_pre[7].adc_h) << 14) - (c_h4 << 20)
                            - r_pre[7].hh5 + 64'd16384, 15);
        n_pre[8].hx = asr64(r_pre[7].hh6, 10);
        n_pre[8].hy = asr64(r_pre[7].hh3, 11) + 64'd32768;

        n_pre[9].v1sq6 = mul_s(r_pre[8].mp_a);
        n_pre[9].v1sq3 = mul_s(r_pre[8].mp_b);
        n_pre[9].mp_c  = mul_p(r_pre[8].hx, r_pre[8].hy);

        n_pre[10].v2  = r_pre[9].v1sq6 + (r_pre[9].v1p5 << 17) + (c_p4 << 35);
        n_pre[10].n1  = asr64(r_pre[9].v1sq3, 8) + (r_pre[9].v1p2 << 12);
        n_pre[10].hb0 = mul_s(r_pre[9].mp_c);

        n_pre[11].n1    = (64'd1 << 47) + r_pre[10].n1;
        n_pre[11].hb1   = asr64(r_pre[10].hb0, 10) + 64'd2097152;
        n_pre[11].pnum0 = ((64'd1048576 - 64'(r_pre[10].adc_p)) << 31) - r_pre[10].v2;

        n_pre[12].mp_a = mul_p(r_pre[11].n1, c_p1);
        n_pre[12].mp_b = mul_p(r_pre[11].pnum0, 64'd3125);
        n_pre[12].mp_c = mul_p(r_pre[11].hb1, c_h2);

        n_pre[13].vdx  = mul_s(r_pre[12].mp_a);
        n_pre[13].pnum = mul_s(r_pre[12].mp_b);
        n_pre[13].hb2x = mul_s(r_pre[12].mp_c);

        n_pre[14].vd  = asr64(r_pre[13].vdx, 33);
        n_pre[14].hb2 = asr64(r_pre[13].hb2x + 64'd8192, 14);

        n_pre[15].mp_a = mul_p(r_pre[14].ha, r_pre[14].hb2);

        n_pre[16].hv = mul_s(r_pre[15].mp_a);

        n_pre[17].mp_b = mul_p(asr64(r_pre[16].hv, 15), asr64(r_pre[16].hv, 15));

        n_pre[18].ss = mul_s(r_pre[17].mp_b);

        n_pre[19].mp_c = mul_p(asr64(r_pre[18].ss, 7), c_h1);

        n_pre[20].hm = mul_s(r_pre[19].mp_c);

        n_pre[21].hv2 = r_pre[20].hv - asr64(r_pre[20].hm, 4);

        // Clamp to the 0 .. 100 %RH range of the Q7.22 intermediate.
        if (r_pre[21].hv2[63])
            n_pre[22].hc = 29'd0;
        else if (r_pre[21].hv2 > HUM_MAX)
            n_pre[22].hc = HUM_MAX[28:0];
        else
            n_pre[22].hc = r_pre[21].hv2[28:0];

        hs = 36'(r_pre[22].hc) * 36'd100;
        n_pre[23].hum = hs[35:22];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NPRE; k++) r_vpre[k] <= 1'b0;
        end else if (en) begin
            r_vpre[1] <= s_axis_tvalid;
            for (int k = 2; k <= NPRE; k++) r_vpre[k] <= r_vpre[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_pre <= n_pre;
    end

    // Pressure division, truncating toward zero; a zero divisor is flagged.
    t_side       div_side_in, div_side;
    logic        div_vld, div_zero;
    logic [63:0] div_quot;

    assign div_side_in.temp = r_pre[NPRE].temp;
    assign div_side_in.hum  = r_pre[NPRE].hum;

    esc_div64 u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_vpre[NPRE]),
        .i_num  (r_pre[NPRE].pnum),
        .i_den  (r_pre[NPRE].vd),
        .i_side (div_side_in),
        .o_vld  (div_vld),
        .o_quot (div_quot),
        .o_zero (div_zero),
        .o_side (div_side)
    );

    // Back section: pressure correction terms and final scaling.
    typedef struct packed {
        t_side       side;
        logic        zero;
        logic [63:0] q, pq;
        t_mpart      mp_a, mp_b;
        logic [63:0] pq9, q8, w2, m, sum, pp, t;
        logic [31:0] pres;
    } t_post;

    t_post r_post [1:NPOST];
    t_post n_post [1:NPOST];
    logic  r_vpost [1:NPOST];

    always_comb begin
        logic [63:0] tb;
        n_post[1] = '0;
        for (int k = 2; k <= NPOST; k++) n_post[k] = r_post[k-1];

        n_post[1].side = div_side;
        n_post[1].zero = div_zero;
        n_post[1].q    = div_quot;
        n_post[1].pq   = asr64(div_quot, 13);
        n_post[1].mp_a = mul_p(asr64(div_quot, 13), c_p9);
        n_post[1].mp_b = mul_p(c_p8, div_quot);

        n_post[2].pq9 = mul_s(r_post[1].mp_a);
        n_post[2].q8  = mul_s(r_post[1].mp_b);

        n_post[3].mp_a = mul_p(r_post[2].pq9, r_post[2].pq);
        n_post[3].w2   = asr64(r_post[2].q8, 19);

        n_post[4].m = mul_s(r_post[3].mp_a);

        n_post[5].sum = r_post[4].q + asr64(r_post[4].m, 25) + r_post[4].w2;

        n_post[6].pp = asr64(r_post[5].sum, 8) + (c_p7 << 4);

        n_post[7].t = (r_post[6].pp << 3) + (r_post[6].pp << 1);

        // Signed divide by 256 toward zero: bias negative values first.
        tb = r_post[7].t + (r_post[7].t[63] ? 64'd255 : 64'd0);
        n_post[8].pres = r_post[7].zero ? 32'd0 : 32'(asr64(tb, 8));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NPOST; k++) r_vpost[k] <= 1'b0;
        end else if (en) begin
            r_vpost[1] <= div_vld;
            for (int k = 2; k <= NPOST; k++) r_vpost[k] <= r_vpost[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_post <= n_post;
    end

    assign m_axis_tvalid = r_vpost[NPOST];
    assign m_axis_tdata  = {2'b00, r_post[NPOST].side.hum, r_post[NPOST].pres,
                            r_post[NPOST].side.temp};

`ifndef SYNTHESIS
    // Humidity never leaves its clamped range.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[61:48] <= 14'd10000))
        else $error("humidity result above 100 percent");

    // A stall freezes the first and last valid bits of the front pipeline.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> ($stable(r_vpre[1]) && $stable(r_vpre[NPRE])))
        else $error("front pipeline moved during a stall");

    // A zero divisor always yields zero pressure.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vpost[NPOST-1] && r_post[NPOST-1].zero)
            |=> (m_axis_tdata[47:16] == 32'd0))
        else $error("nonzero pressure on zero divisor");
`endif

endmodule
